// ===== rtl/bitcrush_hold_dither_quantizer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bitcrusher block
// Shared property wrappers, clocked on the rising edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef BITCRUSH_HOLD_DITHER_QUANTIZER_MACROS_SVH
`define BITCRUSH_HOLD_DITHER_QUANTIZER_MACROS_SVH

// same-cycle implication
`define BHDQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BHDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bhdq_pkg.sv =====
// ---------------------------------------------------------------------------
// bhdq_pkg
// Types and constants shared by the bitcrusher modules.
// ---------------------------------------------------------------------------
package bhdq_pkg;

  localparam int SAMPLE_W = 16;
  localparam int NOISE_W  = 15;
  localparam int DEPTH_W  = 4;
  localparam int RDIV_W   = 7;
  localparam int MIX_W    = 15;
  localparam int CFG_W    = 15;
  localparam int IDX_W    = 2;
  localparam int QNT_W    = 18;  // headroom for dither and rounding

  localparam logic [DEPTH_W-1:0] DEPTH_FULL = 4'd15;
  localparam logic [MIX_W-1:0]   Q15_MAX    = 15'h7FFF;

  localparam logic [IDX_W-1:0] REG_DEPTH_BITS    = 2'd0;
  localparam logic [IDX_W-1:0] REG_RATE_DIVIDER  = 2'd1;
  localparam logic [IDX_W-1:0] REG_WET_MIX       = 2'd2;
  localparam logic [IDX_W-1:0] REG_DITHER_ENABLE = 2'd3;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_bits;
    logic [RDIV_W-1:0]  rate_divider;
    logic [MIX_W-1:0]   wet_mix;
    logic               dither_enable;
  } cfg_t;

  // item after the hold stage
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry;
    logic signed [SAMPLE_W-1:0] held;
    logic [NOISE_W-1:0]         noise_a;
    logic [NOISE_W-1:0]         noise_b;
    logic                       start;
  } hold_item_t;

endpackage

// ===== rtl/bhdq_hold.sv =====
// ---------------------------------------------------------------------------
// bhdq_hold
// Zero-order hold state and the input register of the datapath.
// ---------------------------------------------------------------------------
module bhdq_hold
  import bhdq_pkg::*;
#(
  parameter int MAX_RATE_DIV = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [RDIV_W-1:0]          rate_divider,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [NOISE_W-1:0]         noise_a,
  input  logic [NOISE_W-1:0]         noise_b,
  input  logic                       range_start,
  output hold_item_t                 item
);

  localparam int POS_W = (MAX_RATE_DIV > 1) ? $clog2(MAX_RATE_DIV) : 1;
  localparam int CMP_W = (POS_W + 1 > RDIV_W) ? POS_W + 1 : RDIV_W;

  logic signed [SAMPLE_W-1:0] held_r, held_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt, pos_cur;
  logic [CMP_W-1:0]           rdiv, pos_next_cnt;
  hold_item_t                 item_r, item_nxt;

  always_comb begin
    // zero counts as one, clamp to the hold depth
    priority if (rate_divider == '0) begin
      rdiv = CMP_W'(1);
    end else if (CMP_W'(rate_divider) > CMP_W'(MAX_RATE_DIV)) begin
      rdiv = CMP_W'(MAX_RATE_DIV);
    end else begin
      rdiv = CMP_W'(rate_divider);
    end
    pos_cur      = range_start ? '0 : pos_r;
    held_nxt     = (pos_cur == '0) ? sample_in : held_r;
    pos_next_cnt = CMP_W'(pos_cur) + CMP_W'(1);
    pos_nxt      = (pos_next_cnt >= rdiv) ? '0 : pos_next_cnt[POS_W-1:0];

    item_nxt.dry     = sample_in;
    item_nxt.held    = held_nxt;
    item_nxt.noise_a = noise_a;
    item_nxt.noise_b = noise_b;
    item_nxt.start   = range_start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      pos_r  <= '0;
    end else if (load) begin
      held_r <= held_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign item = item_r;

endmodule

// ===== rtl/bhdq_crush.sv =====
// ---------------------------------------------------------------------------
// bhdq_crush
// TPDF dither, round and floor to the kept depth, clamp to 16 bits.
// ---------------------------------------------------------------------------
module bhdq_crush
  import bhdq_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] held,
  input  logic [NOISE_W-1:0]         noise_a,
  input  logic [NOISE_W-1:0]         noise_b,
  input  cfg_t                       cfg,
  output logic signed [SAMPLE_W-1:0] crushed
);

  localparam logic signed [QNT_W-1:0] POS_LIM = QNT_W'(32767);
  localparam logic signed [QNT_W-1:0] NEG_LIM = -QNT_W'(32768);

  logic [DEPTH_W-1:0]       bits, shift;
  logic signed [QNT_W-1:0]  step, half, mask, d1, d2, dith, biased, floored;

  always_comb begin
    bits  = (cfg.depth_bits == '0) ? DEPTH_W'(1) : cfg.depth_bits;
    shift = DEPTH_FULL - bits;
    step  = QNT_W'(1) <<< shift;
    half  = step >>> 1;
    mask  = ~(step - QNT_W'(1));
    // noise * step >> 15 is noise >> bits
    d1    = QNT_W'(noise_a >> bits);
    d2    = QNT_W'(noise_b >> bits);
    dith  = (cfg.dither_enable && shift != '0) ? (d1 + d2 - step) : '0;
    biased  = QNT_W'(held) + dith + half;
    floored = biased & mask;
    priority if (floored > POS_LIM) begin
      crushed = POS_LIM[SAMPLE_W-1:0];
    end else if (floored < NEG_LIM) begin
      crushed = NEG_LIM[SAMPLE_W-1:0];
    end else begin
      crushed = floored[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== rtl/bhdq_mix.sv =====
// ---------------------------------------------------------------------------
// bhdq_mix
// Q15 dry/wet blend with 16-bit saturation.
// ---------------------------------------------------------------------------
module bhdq_mix
  import bhdq_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] dry,
  input  logic signed [SAMPLE_W-1:0] wet,
  input  logic [MIX_W-1:0]           wet_mix,
  output logic signed [SAMPLE_W-1:0] mixed,
  output logic                       sat
);

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + MIX_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RES_W  = SUM_W - MIX_W;

  localparam logic signed [RES_W-1:0] POS_LIM = RES_W'(32767);
  localparam logic signed [RES_W-1:0] NEG_LIM = -RES_W'(32768);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  base, sum;
  logic signed [RES_W-1:0]  res;

  always_comb begin
    // dry*(32767-w) + wet*w == dry*32767 + (wet-dry)*w
    diff = DIFF_W'(wet) - DIFF_W'(dry);
    prod = PROD_W'(diff) * PROD_W'($signed({1'b0, wet_mix}));
    base = (SUM_W'(dry) <<< MIX_W) - SUM_W'(dry);
    sum  = base + SUM_W'(prod);
    res  = RES_W'(sum >>> MIX_W);
    sat  = 1'b1;
    priority if (res > POS_LIM) begin
      mixed = POS_LIM[SAMPLE_W-1:0];
    end else if (res < NEG_LIM) begin
      mixed = NEG_LIM[SAMPLE_W-1:0];
    end else begin
      mixed = res[SAMPLE_W-1:0];
      sat   = 1'b0;
    end
  end

endmodule

// ===== rtl/bitcrush_hold_dither_quantizer.sv =====
// ---------------------------------------------------------------------------
// bitcrush_hold_dither_quantizer
// Sample-and-hold bitcrusher with optional TPDF dither and dry/wet mix.
// ---------------------------------------------------------------------------
//  channel  | handshake           | payload
//  in       | in_valid/in_stall   | in_sample_in, in_noise_a, in_noise_b, in_range_start
//  out      | out_valid/out_stall | out_sample_out, out_clipped
//  cfg      | cfg_we              | cfg_index, cfg_wdata
//
//  One item per cycle while in_stall is low; an accepted item sits in the hold
//  stage's input register until the output register is free, then moves there.
//  Hold state updates at input; crush and mix sit between the two registers.
//  Reset (rst_n low, synchronous) empties both stages and loads default config.
//  in_stall rises only when both stages are full and out_stall is high.
// ---------------------------------------------------------------------------
module bitcrush_hold_dither_quantizer
  import bhdq_pkg::*;
#(
  parameter int MAX_RATE_DIV = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic [NOISE_W-1:0]         in_noise_a,
  input  logic [NOISE_W-1:0]         in_noise_b,
  input  logic                       in_range_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_clipped,
  input  logic                       cfg_we,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  `include "bitcrush_hold_dither_quantizer_macros.svh"

  cfg_t                       cfg_r, cfg_nxt;
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       clip_r, clip_nxt;
  logic signed [SAMPLE_W-1:0] out_r;
  logic                       s2_ld, s1_adv, in_acc;
  hold_item_t                 s1_item;
  logic signed [SAMPLE_W-1:0] crushed, mixed;
  logic                       sat;

  // configuration
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH_BITS:    cfg_nxt.depth_bits    = cfg_wdata[DEPTH_W-1:0];
        REG_RATE_DIVIDER:  cfg_nxt.rate_divider  = cfg_wdata[RDIV_W-1:0];
        REG_WET_MIX:       cfg_nxt.wet_mix       = cfg_wdata[MIX_W-1:0];
        REG_DITHER_ENABLE: cfg_nxt.dither_enable = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_bits    <= DEPTH_FULL;
      cfg_r.rate_divider  <= RDIV_W'(1);
      cfg_r.wet_mix       <= Q15_MAX;
      cfg_r.dither_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pipeline control
  assign s2_ld    = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && s2_ld;
  assign in_stall = s1_valid_r && !s2_ld;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s2_ld ? 1'b0 : s1_valid_r);
    out_valid_nxt = s2_ld ? s1_valid_r : out_valid_r;
    clip_nxt      = (s1_item.start ? 1'b0 : clip_r) | sat;
  end

  bhdq_hold #(
    .MAX_RATE_DIV(MAX_RATE_DIV)
  ) u_hold (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_acc),
    .rate_divider(cfg_r.rate_divider),
    .sample_in   (in_sample_in),
    .noise_a     (in_noise_a),
    .noise_b     (in_noise_b),
    .range_start (in_range_start),
    .item        (s1_item)
  );

  bhdq_crush u_crush (
    .held   (s1_item.held),
    .noise_a(s1_item.noise_a),
    .noise_b(s1_item.noise_b),
    .cfg    (cfg_r),
    .crushed(crushed)
  );

  bhdq_mix u_mix (
    .dry    (s1_item.dry),
    .wet    (crushed),
    .wet_mix(cfg_r.wet_mix),
    .mixed  (mixed),
    .sat    (sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      clip_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        clip_r <= clip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= mixed;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;
  assign out_clipped    = clip_r;

  // assertions
  `BHDQ_ASSERT_SAME(a_stall_needs_full, clk, rst_n, in_stall,
                    s1_valid_r && out_valid_r, "input stalled with a free stage")
  `BHDQ_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, s1_adv,
                    out_valid_r, "item advanced but output register empty")
  `BHDQ_ASSERT_SAME(a_mix_in_range, clk, rst_n, s1_valid_r,
                    !sat, "blend left the 16-bit range")

endmodule
